// ===== hdl/itf_pkg.sv =====
// Shared constants, types and helpers for the integer-to-text formatter.
// No dependencies; every other file of the block imports this package.
package itf_pkg;

    // Field geometry.
    localparam int MAX_FIELD   = 64;
    localparam int MAX_DIGITS  = 22;
    localparam int VALUE_W     = 64;
    localparam int TYPE_W      = 3;
    localparam int SIZE_W      = 2;
    localparam int FLD_W       = 6;
    localparam int CH_W        = 7;
    localparam int DIGIT_W     = 4;
    localparam int CNT_W       = $clog2(MAX_FIELD + 1);
    localparam int NDIG_W      = $clog2(MAX_DIGITS + 1);
    localparam int DIG_IDX_W   = $clog2(MAX_DIGITS);
    localparam int STEP_W      = $clog2(VALUE_W / 2 + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Conversion type codes.
    localparam logic [TYPE_W-1:0] REQ_SDEC = 3'd0;
    localparam logic [TYPE_W-1:0] REQ_UDEC = 3'd1;
    localparam logic [TYPE_W-1:0] REQ_OCT  = 3'd2;
    localparam logic [TYPE_W-1:0] REQ_HEXL = 3'd3;
    localparam logic [TYPE_W-1:0] REQ_HEXU = 3'd4;

    // Length modifier codes.
    localparam logic [SIZE_W-1:0] SIZE_INT   = 2'd0;
    localparam logic [SIZE_W-1:0] SIZE_SHORT = 2'd1;
    localparam logic [SIZE_W-1:0] SIZE_LONG  = 2'd2;

    // ASCII codes.
    localparam logic [CH_W-1:0] CH_SPACE    = 7'd32;
    localparam logic [CH_W-1:0] CH_PLUS     = 7'd43;
    localparam logic [CH_W-1:0] CH_MINUS    = 7'd45;
    localparam logic [CH_W-1:0] CH_DIGIT0   = 7'd48;
    localparam logic [CH_W-1:0] CH_ALPHA_UP = 7'd55;
    localparam logic [CH_W-1:0] CH_ALPHA_LO = 7'd87;
    localparam logic [CH_W-1:0] CH_X_UP     = 7'd88;
    localparam logic [CH_W-1:0] CH_X_LO     = 7'd120;
    localparam logic [DIGIT_W-1:0] DEC_RADIX = 4'd10;

    typedef enum logic [1:0] {
        KIND_DEC = 2'd0,
        KIND_OCT = 2'd1,
        KIND_HEX = 2'd2
    } t_kind;

    typedef logic [DIGIT_W-1:0]                  t_digit;
    typedef logic [MAX_DIGITS-1:0][DIGIT_W-1:0]  t_digits;

    // One classified request as it travels from the front to the back.
    typedef struct packed {
        logic [VALUE_W-1:0] bits;      // aligned magnitude for decimal, raw magnitude otherwise
        logic [STEP_W-1:0]  steps;     // two-bit conversion steps for decimal
        t_kind              kind;
        logic               upper;
        logic               mag_zero;
        logic [1:0]         plen;
        logic [CH_W-1:0]    pre0;
        logic [CH_W-1:0]    pre1;
        logic               oct_alt;
        logic               left;
        logic               zfill;
        logic [FLD_W-1:0]   width;
        logic               hasp;
        logic [FLD_W-1:0]   prec;
    } t_desc;

    // ASCII character of one digit.
    function automatic logic [CH_W-1:0] digit_char(t_digit d, logic upper);
        logic [CH_W-1:0] ofs;
        if (d < DEC_RADIX) begin
            ofs = CH_DIGIT0;
        end else if (upper) begin
            ofs = CH_ALPHA_UP;
        end else begin
            ofs = CH_ALPHA_LO;
        end
        return ofs + CH_W'(d);
    endfunction

endpackage

// ===== hdl/itf_req_if.sv =====
// Request channel of the formatter: valid/ready handshake and the conversion request.
// Depends on itf_pkg for field widths.
interface itf_req_if import itf_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [VALUE_W-1:0]  value;
    logic [TYPE_W-1:0]          req_type;
    logic [SIZE_W-1:0]          size_mod;
    logic                       flag_left;
    logic                       flag_plus;
    logic                       flag_space;
    logic                       flag_zero;
    logic                       flag_alt;
    logic [FLD_W-1:0]           width;
    logic                       has_precision;
    logic [FLD_W-1:0]           precision;

    modport source (
        output valid, value, req_type, size_mod, flag_left, flag_plus, flag_space,
               flag_zero, flag_alt, width, has_precision, precision,
        input  ready
    );
    modport sink (
        input  valid, value, req_type, size_mod, flag_left, flag_plus, flag_space,
               flag_zero, flag_alt, width, has_precision, precision,
        output ready
    );
endinterface

// ===== hdl/itf_rsp_if.sv =====
// Result channel of the formatter: one ASCII character per transfer with a last marker.
// Depends on itf_pkg for field widths.
interface itf_rsp_if import itf_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] ch;
    logic            last;

    modport source (output valid, ch, last, input ready);
    modport sink (input valid, ch, last, output ready);
endinterface

// ===== hdl/itf_front.sv =====
// Front end: accepts a conversion request, truncates and classifies it.
// Depends on itf_pkg and itf_req_if; feeds the descriptor queue.
module itf_front import itf_pkg::*; (
    itf_req_if.sink     i_req,
    input  logic        i_full,
    output logic        o_push,
    output t_desc       o_desc
);

    logic [VALUE_W-1:0] w_raw;
    logic [VALUE_W-1:0] w_neg_raw;
    logic [VALUE_W-1:0] w_mask;
    logic [VALUE_W-1:0] w_mag;
    logic               w_sign_bit;
    logic               w_neg;
    logic               w_signed;

    assign w_raw     = i_req.value;
    assign w_neg_raw = ~w_raw + VALUE_W'(1);
    assign w_signed  = (i_req.req_type == REQ_SDEC);

    // Request is taken whenever the queue has room.
    assign i_req.ready = !i_full;
    assign o_push      = i_req.valid && !i_full;

    // Truncate to the selected size and find the sign.
    always_comb begin
        unique case (i_req.size_mod)
            SIZE_SHORT: begin
                w_mask     = {{(VALUE_W-16){1'b0}}, {16{1'b1}}};
                w_sign_bit = w_raw[15];
            end
            SIZE_INT: begin
                w_mask     = {{(VALUE_W-32){1'b0}}, {32{1'b1}}};
                w_sign_bit = w_raw[31];
            end
            default: begin
                w_mask     = '1;
                w_sign_bit = w_raw[VALUE_W-1];
            end
        endcase
        w_neg = w_signed && w_sign_bit;
        w_mag = (w_neg ? w_neg_raw : w_raw) & w_mask;
    end

    // Build the descriptor: kind, aligned bits for the decimal converter, prefix.
    always_comb begin
        o_desc = '0;
        unique case (i_req.req_type)
            REQ_OCT:  o_desc.kind = KIND_OCT;
            REQ_HEXL: o_desc.kind = KIND_HEX;
            REQ_HEXU: o_desc.kind = KIND_HEX;
            default:  o_desc.kind = KIND_DEC;
        endcase
        o_desc.upper    = (i_req.req_type == REQ_HEXU);
        o_desc.mag_zero = (w_mag == '0);

        // Decimal conversion walks the bits from the top, so the value is left-aligned.
        if (o_desc.kind == KIND_DEC) begin
            unique case (i_req.size_mod)
                SIZE_SHORT: begin
                    o_desc.bits  = {w_mag[15:0], {(VALUE_W-16){1'b0}}};
                    o_desc.steps = STEP_W'(8);
                end
                SIZE_INT: begin
                    o_desc.bits  = {w_mag[31:0], {(VALUE_W-32){1'b0}}};
                    o_desc.steps = STEP_W'(16);
                end
                default: begin
                    o_desc.bits  = w_mag;
                    o_desc.steps = STEP_W'(VALUE_W / 2);
                end
            endcase
        end else begin
            o_desc.bits  = w_mag;
            o_desc.steps = STEP_W'(1);
        end

        // Sign for signed decimal, 0x or 0X for nonzero hex in alternate form.
        o_desc.pre0 = CH_DIGIT0;
        o_desc.pre1 = CH_SPACE;
        o_desc.plen = 2'd0;
        if (w_signed) begin
            if (w_neg) begin
                o_desc.pre1 = CH_MINUS;
                o_desc.plen = 2'd1;
            end else if (i_req.flag_plus) begin
                o_desc.pre1 = CH_PLUS;
                o_desc.plen = 2'd1;
            end else if (i_req.flag_space) begin
                o_desc.pre1 = CH_SPACE;
                o_desc.plen = 2'd1;
            end
        end else if (o_desc.kind == KIND_HEX && i_req.flag_alt && !o_desc.mag_zero) begin
            o_desc.pre1 = o_desc.upper ? CH_X_UP : CH_X_LO;
            o_desc.plen = 2'd2;
        end

        o_desc.oct_alt = (o_desc.kind == KIND_OCT) && i_req.flag_alt;
        o_desc.left    = i_req.flag_left;
        o_desc.zfill   = i_req.flag_zero && !i_req.flag_left && !i_req.has_precision;
        o_desc.width   = i_req.width;
        o_desc.hasp    = i_req.has_precision;
        o_desc.prec    = i_req.precision;
    end

endmodule

// ===== hdl/itf_queue.sv =====
// Short descriptor queue between the front end and the back end.
// Depends on itf_pkg for the descriptor type and depth.
module itf_queue import itf_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_desc  i_desc,
    output logic   o_full,
    input  logic   i_pop,
    output t_desc  o_desc,
    output logic   o_empty
);

    t_desc              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic [QPTR_W-1:0]  n_wr_ptr;
    logic [QPTR_W-1:0]  n_rd_ptr;
    logic [QCNT_W-1:0]  n_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_desc  = r_mem[r_rd_ptr];

    // Pointer and occupancy update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("queue read while empty");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not follow a lone write");

endmodule

// ===== hdl/itf_back.sv =====
// Back end: digit extraction, field layout and character emission.
// Depends on itf_pkg and itf_rsp_if; pops descriptors from the queue.
module itf_back import itf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_desc       i_desc,
    output logic        o_pop,
    itf_rsp_if.source   o_rsp
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_CONV   = 9'b000000010,
        S_SIZE   = 9'b000000100,
        S_LAYOUT = 9'b000001000,
        S_PADL   = 9'b000010000,
        S_PRE    = 9'b000100000,
        S_ZERO   = 9'b001000000,
        S_DIG    = 9'b010000000,
        S_PADR   = 9'b100000000
    } t_bstate;

    t_bstate             r_state, n_state;
    t_desc               r_desc, n_desc;
    t_digits             r_store, n_store;
    logic [VALUE_W-1:0]  r_bits, n_bits;
    logic [STEP_W-1:0]   r_steps, n_steps;
    logic [NDIG_W-1:0]   r_ndig, n_ndig;
    logic [1:0]          r_plen, n_plen;
    logic [CNT_W-1:0]    r_zeros, n_zeros;
    logic [CNT_W-1:0]    r_pad, n_pad;
    logic [CNT_W-1:0]    r_total, n_total;
    logic                r_out_valid, n_out_valid;
    logic [CH_W-1:0]     r_out_ch, n_out_ch;
    logic                r_out_last, n_out_last;

    logic                w_can_push;
    logic                w_emit;
    logic [CH_W-1:0]     w_ch;
    logic [DIG_IDX_W-1:0] w_dig_idx;
    logic [NDIG_W-1:0]   w_found;
    logic [CNT_W-1:0]    w_ndig_x;
    logic [CNT_W-1:0]    w_prec_x;
    logic [CNT_W-1:0]    w_zeros0;
    logic [CNT_W-1:0]    w_zeros1;
    logic [CNT_W-1:0]    w_zeros2;
    logic [CNT_W-1:0]    w_body;
    logic [CNT_W-1:0]    w_body2;
    logic [CNT_W-1:0]    w_pad;
    logic [CNT_W-1:0]    w_lay_zeros;
    logic [CNT_W-1:0]    w_lay_pad;
    logic [CNT_W-1:0]    w_lay_total;

    // Two shift-and-add-3 steps of the binary to BCD conversion.
    function automatic t_digits dabble2(t_digits d_in, logic [1:0] b);
        t_digits d;
        t_digits c;
        d = d_in;
        for (int s = 0; s < 2; s++) begin
            for (int i = 0; i < MAX_DIGITS; i++) begin
                c[i] = (d[i] >= t_digit'(5)) ? d[i] + t_digit'(3) : d[i];
            end
            d[0] = {c[0][DIGIT_W-2:0], b[1-s]};
            for (int i = 1; i < MAX_DIGITS; i++) begin
                d[i] = {c[i][DIGIT_W-2:0], c[i-1][DIGIT_W-1]};
            end
        end
        return d;
    endfunction

    // Octal and hex digits are plain bit groups of the magnitude.
    function automatic t_digits split_bits(logic [VALUE_W-1:0] v, t_kind k);
        t_digits d;
        d = '0;
        if (k == KIND_HEX) begin
            for (int i = 0; i < VALUE_W / 4; i++) begin
                d[i] = v[4*i +: 4];
            end
        end else begin
            for (int i = 0; i < VALUE_W / 3; i++) begin
                d[i] = t_digit'(v[3*i +: 3]);
            end
            d[VALUE_W / 3] = t_digit'(v[VALUE_W-1]);
        end
        return d;
    endfunction

    // Number of significant digits held in the store.
    always_comb begin
        w_found = '0;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (r_store[i] != '0) begin
                w_found = NDIG_W'(i + 1);
            end
        end
    end

    // Field layout: precision zeros, octal marker, overflow trim, width padding.
    always_comb begin
        w_ndig_x = CNT_W'(r_ndig);
        w_prec_x = CNT_W'(r_desc.prec);
        w_zeros0 = (r_desc.hasp && w_prec_x > w_ndig_x) ? w_prec_x - w_ndig_x : '0;
        if (r_desc.oct_alt && w_zeros0 == '0 && (r_ndig == '0 || !r_desc.mag_zero)) begin
            w_zeros1 = CNT_W'(1);
        end else begin
            w_zeros1 = w_zeros0;
        end
        w_body = CNT_W'(r_desc.plen) + w_zeros1 + w_ndig_x;
        if (w_body > CNT_W'(MAX_FIELD)) begin
            w_zeros2 = w_zeros1 - (w_body - CNT_W'(MAX_FIELD));
            w_body2  = CNT_W'(MAX_FIELD);
        end else begin
            w_zeros2 = w_zeros1;
            w_body2  = w_body;
        end
        w_pad = (CNT_W'(r_desc.width) > w_body2) ? CNT_W'(r_desc.width) - w_body2 : '0;
        w_lay_total = w_body2 + w_pad;
        if (r_desc.zfill) begin
            w_lay_zeros = w_zeros2 + w_pad;
            w_lay_pad   = '0;
        end else begin
            w_lay_zeros = w_zeros2;
            w_lay_pad   = w_pad;
        end
    end

    assign w_can_push = !r_out_valid || o_rsp.ready;
    assign w_dig_idx  = DIG_IDX_W'(r_ndig - 1'b1);

    // Sequencer: load, convert (decimal only), count, lay out, then emit one segment after another.
    always_comb begin
        n_state     = r_state;
        n_desc      = r_desc;
        n_store     = r_store;
        n_bits      = r_bits;
        n_steps     = r_steps;
        n_ndig      = r_ndig;
        n_plen      = r_plen;
        n_zeros     = r_zeros;
        n_pad       = r_pad;
        n_total     = r_total;
        n_out_valid = r_out_valid;
        n_out_ch    = r_out_ch;
        n_out_last  = r_out_last;
        o_pop       = 1'b0;
        w_emit      = 1'b0;
        w_ch        = CH_SPACE;

        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_desc  = i_desc;
                    n_bits  = i_desc.bits;
                    n_steps = i_desc.steps;
                    if (i_desc.kind == KIND_DEC) begin
                        n_store = '0;
                        n_state = S_CONV;
                    end else begin
                        n_store = split_bits(i_desc.bits, i_desc.kind);
                        n_state = S_SIZE;
                    end
                end
            end
            S_CONV: begin
                n_store = dabble2(r_store, r_bits[VALUE_W-1 -: 2]);
                n_bits  = r_bits << 2;
                n_steps = r_steps - 1'b1;
                if (r_steps == STEP_W'(1)) begin
                    n_state = S_SIZE;
                end
            end
            S_SIZE: begin
                if (r_desc.mag_zero) begin
                    n_ndig = (r_desc.hasp && r_desc.prec == '0) ? '0 : NDIG_W'(1);
                end else begin
                    n_ndig = w_found;
                end
                n_state = S_LAYOUT;
            end
            S_LAYOUT: begin
                n_plen  = r_desc.plen;
                n_zeros = w_lay_zeros;
                n_pad   = w_lay_pad;
                n_total = w_lay_total;
                n_state = (w_lay_total == '0) ? S_IDLE : S_PADL;
            end
            S_PADL: begin
                if (r_desc.left || r_pad == '0) begin
                    n_state = S_PRE;
                end else if (w_can_push) begin
                    w_emit = 1'b1;
                    w_ch   = CH_SPACE;
                    n_pad  = r_pad - 1'b1;
                end
            end
            S_PRE: begin
                if (r_plen == '0) begin
                    n_state = S_ZERO;
                end else if (w_can_push) begin
                    w_emit = 1'b1;
                    w_ch   = (r_plen == 2'd2) ? r_desc.pre0 : r_desc.pre1;
                    n_plen = r_plen - 1'b1;
                end
            end
            S_ZERO: begin
                if (r_zeros == '0) begin
                    n_state = S_DIG;
                end else if (w_can_push) begin
                    w_emit  = 1'b1;
                    w_ch    = CH_DIGIT0;
                    n_zeros = r_zeros - 1'b1;
                end
            end
            S_DIG: begin
                if (r_ndig == '0) begin
                    n_state = S_PADR;
                end else if (w_can_push) begin
                    w_emit = 1'b1;
                    w_ch   = digit_char(r_store[w_dig_idx], r_desc.upper);
                    n_ndig = r_ndig - 1'b1;
                end
            end
            S_PADR: begin
                if (!r_desc.left || r_pad == '0) begin
                    n_state = S_IDLE;
                end else if (w_can_push) begin
                    w_emit = 1'b1;
                    w_ch   = CH_SPACE;
                    n_pad  = r_pad - 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Output register: load a new character or drain the taken one.
        if (w_emit) begin
            n_out_valid = 1'b1;
            n_out_ch    = w_ch;
            n_out_last  = (r_total == CNT_W'(1));
            n_total     = r_total - 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_desc     <= n_desc;
        r_store    <= n_store;
        r_bits     <= n_bits;
        r_steps    <= n_steps;
        r_ndig     <= n_ndig;
        r_plen     <= n_plen;
        r_zeros    <= n_zeros;
        r_pad      <= n_pad;
        r_out_ch   <= n_out_ch;
        r_out_last <= n_out_last;
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.ch    = r_out_ch;
    assign o_rsp.last  = r_out_last;

    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_total == '0))
        else $error("field characters left over when returning to idle");

    a_emit_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> (r_total != '0)) else $error("character emitted beyond the field length");

    a_conv_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CONV) |-> (r_steps != '0))
        else $error("decimal conversion running with no steps left");

endmodule

// ===== hdl/integer_to_text_formatter_unit.sv =====
// Top level of the integer-to-text formatter: front end, descriptor queue, back end.
// Depends on itf_pkg, itf_req_if, itf_rsp_if, itf_front, itf_queue and itf_back.
//
//  Port    | Direction | Handshake     | Contents
//  --------+-----------+---------------+--------------------------------------------
//  i_req   | in        | valid / ready | value, type, size, flags, width, precision
//  o_rsp   | out       | valid / ready | one ASCII character, last marks field end
//
// Octal and hex digits are split off the magnitude as the request is loaded;
// decimal converts 16, 32 or 64 bits (short, int, long) in a loop;
// the binary to BCD loop converts two bits per cycle. Each of the five field
// segments is entered, empty or not; a field with no characters goes back to
// idle from the layout state. The emitting segment waits while the sink stalls.
// Reset is synchronous and clears the queue, the sequencer and the output valid
// flag only. Up to two requests queue while the back end works, and the output
// register lets the sink stall without losing a character.
module integer_to_text_formatter_unit import itf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    itf_req_if.sink     i_req,
    itf_rsp_if.source   o_rsp
);

    t_desc w_front_desc;
    t_desc w_queue_desc;
    logic  w_push;
    logic  w_full;
    logic  w_pop;
    logic  w_empty;

    // Classify incoming requests.
    itf_front u_front (
        .i_req   (i_req),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_desc  (w_front_desc)
    );

    // Decouple the front end from the back end.
    itf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_desc  (w_front_desc),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_desc  (w_queue_desc),
        .o_empty (w_empty)
    );

    // Convert and emit characters.
    itf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_desc  (w_queue_desc),
        .o_pop   (w_pop),
        .o_rsp   (o_rsp)
    );

endmodule
